FILE: rtl/core/psa_pkg.sv
package psa_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned RATE_W  = 12;

  localparam int unsigned SLOTS_DEFAULT = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(128);

  // opcode values
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // one ready-table row (valid bit kept in flops beside the memory)
  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [PRIO_W-1:0]  job_priority;
    logic [BURST_W-1:0] job_burst;
    logic [WAIT_W-1:0]  wait_cnt;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clear;
    logic strobe;
  } pick_ctrl_t;

endpackage

FILE: rtl/core/psa_if.sv
interface psa_req_if import psa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [ID_W-1:0]    job_id;
  logic [PRIO_W-1:0]  job_priority;
  logic [BURST_W-1:0] job_burst;

  modport source (output valid, output opcode, output job_id, output job_priority,
                  output job_burst, input ready);
  modport sink   (input valid, input opcode, input job_id, input job_priority,
                  input job_burst, output ready);
endinterface

interface psa_rsp_if import psa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              arrival_rejected;
  logic              running_valid;
  logic [ID_W-1:0]   running_id;
  logic              finished_valid;
  logic [ID_W-1:0]   finished_id;
  logic [STEP_W-1:0] finished_step;
  logic [WAIT_W-1:0] finished_wait;

  modport source (output valid, output arrival_rejected, output running_valid,
                  output running_id, output finished_valid, output finished_id,
                  output finished_step, output finished_wait, input ready);
  modport sink   (input valid, input arrival_rejected, input running_valid,
                  input running_id, input finished_valid, input finished_id,
                  input finished_step, input finished_wait, output ready);
endinterface

FILE: rtl/core/psa_table_ram.sv
module psa_table_ram import psa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/core/psa_picker.sv
module psa_picker import psa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pick_ctrl_t               ctrl_i,
  input  logic [$clog2(SLOTS)-1:0] idx_i,
  input  entry_t                   entry_i,
  output logic                     found_o,
  output logic [$clog2(SLOTS)-1:0] idx_o,
  output entry_t                   entry_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  logic             found_q;
  logic [IDX_W-1:0] idx_q;
  entry_t           best_q;
  logic             better;

  // strict compare: entries arrive in ascending slot order, so equal keys keep the lower slot
  always_comb begin
    better = !found_q
          || (entry_i.job_priority < best_q.job_priority)
          || ((entry_i.job_priority == best_q.job_priority)
              && (entry_i.job_burst < best_q.job_burst));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctrl_i.strobe) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.strobe && !ctrl_i.clear && better) begin
      idx_q  <= idx_i;
      best_q <= entry_i;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign entry_o = best_q;

endmodule

FILE: rtl/core/priority_scheduler_with_aging.sv
// Non-preemptive priority scheduler with aging.
// req_i (valid/ready) carries one item per transfer: opcode arrive admits a job
// into the ready table, opcode tick runs one scheduling step. rsp_o returns
// exactly one result transfer per request transfer, in order.
// cfg_we_i/cfg_wdata_i write the Q4.8 aging rate; only write while idle.
// An arrive scans the slots upward from slot zero to the lowest free one
// (rejected when the table is full); a tick makes one pass that reads every
// row of the table memory once (one read port and one write port), picks the
// best candidate and writes the aged row back in the cycle after its read.
// One item is in work at a time; req_i.ready is high only between items.
// The result sits in an output register; if rsp_o stalls, the next item is
// still taken and worked on, and it parks in its final state until the
// register drains.
// Reset: table empty (valid flops cleared, no memory clearing pass), nothing
// running, step count zero, aging rate 0.5.
module priority_scheduler_with_aging import psa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  psa_req_if.sink           req_i,
  psa_rsp_if.source         rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

  state_e state_q, state_d;

  // scan counter and read pipeline
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic [SLOTS-1:0]  valid_q;
  logic [RATE_W-1:0] rate_q;

  // captured request
  logic   op_q;
  entry_t new_q;

  // running job
  logic               run_valid_q;
  logic [ID_W-1:0]    run_id_q;
  logic [BURST_W-1:0] run_burst_q;
  logic [BURST_W-1:0] run_exec_q;
  logic [WAIT_W-1:0]  run_wait_q;
  logic [STEP_W-1:0]  step_q;

  // per-item result pieces
  logic              rej_q;
  logic              fin_q;
  logic [ID_W-1:0]   fin_id_q;
  logic [STEP_W-1:0] fin_step_q;
  logic [WAIT_W-1:0] fin_wait_q;

  // output register
  logic              out_valid_q;
  logic              out_rej_q;
  logic              out_run_valid_q;
  logic [ID_W-1:0]   out_run_id_q;
  logic              out_fin_q;
  logic [ID_W-1:0]   out_fin_id_q;
  logic [STEP_W-1:0] out_fin_step_q;
  logic [WAIT_W-1:0] out_fin_wait_q;

  // control
  logic             accept, out_free, commit, scan_end, free_hit, row_live, retire;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata, ram_rdata, aged;
  pick_ctrl_t       pick_ctrl;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  entry_t           best;

  // next running-job view
  logic               dispatch;
  logic               run_valid_n;
  logic [ID_W-1:0]    run_id_n;
  logic [BURST_W-1:0] run_burst_n;
  logic [BURST_W-1:0] run_exec_n;
  logic [WAIT_W-1:0]  run_wait_n;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign scan_end = (idx_q == CNT_END);
  assign free_hit = !scan_end && !valid_q[idx_q[IDX_W-1:0]];
  assign row_live = rd_vld_q && valid_q[rd_idx_q];
  assign retire   = (req_i.opcode == OP_TICK) && run_valid_q && (run_exec_q >= run_burst_q);

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = (req_i.opcode == OP_ARRIVE) ? ST_FREE : ST_SCAN;
        end
      end
      ST_FREE: begin
        if (scan_end || free_hit) begin
          state_d = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready      = 1'b0;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = rd_idx_q;
    ram_wdata        = aged;
    pick_ctrl.clear  = 1'b0;
    pick_ctrl.strobe = 1'b0;
    commit           = 1'b0;
    idx_d            = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready     = 1'b1;
        pick_ctrl.clear = req_i.valid;
        idx_d           = '0;
      end
      ST_FREE: begin
        if (free_hit) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[IDX_W-1:0];
          ram_wdata = new_q;
        end else if (!scan_end) begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        ram_re           = !scan_end;
        ram_we           = row_live;
        pick_ctrl.strobe = row_live;
        if (!scan_end) begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_FIN: begin
        commit = out_free;
      end
      default: ;
    endcase
  end

  // aging of the row read last cycle: priority floors at zero, wait saturates
  always_comb begin
    aged = ram_rdata;
    if (ram_rdata.job_priority > PRIO_W'(rate_q)) begin
      aged.job_priority = ram_rdata.job_priority - PRIO_W'(rate_q);
    end else begin
      aged.job_priority = '0;
    end
    if (ram_rdata.wait_cnt != '1) begin
      aged.wait_cnt = ram_rdata.wait_cnt + WAIT_W'(1);
    end
  end

  // ---------------- table memory and best-row picker ----------------
  psa_table_ram #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  psa_picker #(
    .SLOTS (SLOTS)
  ) u_picker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pick_ctrl),
    .idx_i   (rd_idx_q),
    .entry_i (ram_rdata),
    .found_o (best_found),
    .idx_o   (best_idx),
    .entry_o (best)
  );

  // ---------------- end-of-tick update of the running job ----------------
  // the picked row's aged copy in memory is stale, but its valid bit drops here
  always_comb begin
    dispatch    = (op_q == OP_TICK) && !run_valid_q && best_found;
    run_valid_n = run_valid_q || dispatch;
    run_id_n    = dispatch ? best.job_id : run_id_q;
    run_burst_n = dispatch ? best.job_burst : run_burst_q;
    run_wait_n  = dispatch ? best.wait_cnt : run_wait_q;
    run_exec_n  = run_exec_q;
    if (dispatch) begin
      run_exec_n = BURST_W'(1);
    end else if ((op_q == OP_TICK) && run_valid_q && (run_exec_q != '1)) begin
      run_exec_n = run_exec_q + BURST_W'(1);
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      rate_q      <= RATE_RESET;
      run_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= ram_re;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (ram_we && (state_q == ST_FREE)) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (accept && retire) begin
        run_valid_q <= 1'b0;
      end
      if (commit && (op_q == OP_TICK)) begin
        run_valid_q <= run_valid_n;
        step_q      <= step_q + STEP_W'(1);
        if (dispatch) begin
          valid_q[best_idx] <= 1'b0;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q[IDX_W-1:0];
    if (accept) begin
      op_q                <= req_i.opcode;
      new_q.job_id        <= req_i.job_id;
      new_q.job_priority  <= req_i.job_priority;
      new_q.job_burst     <= req_i.job_burst;
      new_q.wait_cnt      <= '0;
      rej_q               <= 1'b0;
      fin_q               <= retire;
      fin_id_q            <= retire ? run_id_q : '0;
      fin_step_q          <= retire ? step_q : '0;
      fin_wait_q          <= retire ? run_wait_q : '0;
    end
    if ((state_q == ST_FREE) && scan_end) begin
      rej_q <= 1'b1;
    end
    if (commit && (op_q == OP_TICK)) begin
      run_id_q    <= run_id_n;
      run_burst_q <= run_burst_n;
      run_exec_q  <= run_exec_n;
      run_wait_q  <= run_wait_n;
    end
    if (commit) begin
      out_rej_q       <= rej_q;
      out_run_valid_q <= run_valid_n;
      out_run_id_q    <= run_valid_n ? run_id_n : '0;
      out_fin_q       <= fin_q;
      out_fin_id_q    <= fin_id_q;
      out_fin_step_q  <= fin_step_q;
      out_fin_wait_q  <= fin_wait_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.arrival_rejected = out_rej_q;
  assign rsp_o.running_valid    = out_run_valid_q;
  assign rsp_o.running_id       = out_run_id_q;
  assign rsp_o.finished_valid   = out_fin_q;
  assign rsp_o.finished_id      = out_fin_id_q;
  assign rsp_o.finished_step    = out_fin_step_q;
  assign rsp_o.finished_wait    = out_fin_wait_q;

endmodule

FILE: tb/tb_priority_scheduler_with_aging.sv
module tb_priority_scheduler_with_aging import psa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = SLOTS_DEFAULT;
  // Settling pause once the last result is in: one full tick pass plus margin.
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;

  // ---------------------------------------------------------------------------
  // Scheduler state as the bench sees it
  // ---------------------------------------------------------------------------
  typedef struct packed {
    bit               valid;
    bit [ID_W-1:0]    id;
    bit [PRIO_W-1:0]  prio;
    bit [BURST_W-1:0] burst;
    bit [WAIT_W-1:0]  wait_cnt;
  } ready_row_t;

  typedef struct packed {
    bit               valid;
    bit [ID_W-1:0]    id;
    bit [BURST_W-1:0] burst;
    bit [BURST_W-1:0] exec_cnt;
    bit [WAIT_W-1:0]  wait_cnt;
  } job_t;

  typedef struct packed {
    bit              arrival_rejected;
    bit              running_valid;
    bit [ID_W-1:0]   running_id;
    bit              finished_valid;
    bit [ID_W-1:0]   finished_id;
    bit [STEP_W-1:0] finished_step;
    bit [WAIT_W-1:0] finished_wait;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [RATE_W-1:0] cfg_wdata_i;

  psa_req_if req ();
  psa_rsp_if rsp ();

  priority_scheduler_with_aging #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  ready_row_t        ready_rows[SLOTS];
  job_t              active_job;
  bit [STEP_W-1:0]   step_no;
  bit [RATE_W-1:0]   aging_rate_q48;

  outcome_t outcome_q[$];
  int       mismatch_cnt = 0;

  // Handshake pressure knobs, read by the sender task and the receiver process.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_left       = 0;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scheduler behaviour, advanced once per accepted request transfer
  // ---------------------------------------------------------------------------
  function automatic outcome_t advance_schedule(input logic op, input bit [ID_W-1:0] id,
                                                input bit [PRIO_W-1:0] prio,
                                                input bit [BURST_W-1:0] burst);
    outcome_t r;
    int       slot;
    int       best;
    r = '0;
    if (op == OP_ARRIVE) begin
      // lowest free row takes the job, a full table flags a rejection
      slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !ready_rows[i].valid) slot = i;
      end
      if (slot < 0) begin
        r.arrival_rejected = 1'b1;
      end else begin
        ready_rows[slot].valid    = 1'b1;
        ready_rows[slot].id       = id;
        ready_rows[slot].prio     = prio;
        ready_rows[slot].burst    = burst;
        ready_rows[slot].wait_cnt = '0;
      end
    end else begin
      // retire: exec >= burst, so a zero burst still runs for one tick
      if (active_job.valid && active_job.exec_cnt >= active_job.burst) begin
        r.finished_valid = 1'b1;
        r.finished_id    = active_job.id;
        r.finished_step  = step_no;
        r.finished_wait  = active_job.wait_cnt;
        active_job       = '0;
      end
      // dispatch: lowest priority, then shorter burst, then lower row
      if (!active_job.valid) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (ready_rows[i].valid &&
              (best < 0 || ready_rows[i].prio < ready_rows[best].prio ||
               (ready_rows[i].prio == ready_rows[best].prio &&
                ready_rows[i].burst < ready_rows[best].burst)))
            best = i;
        end
        if (best >= 0) begin
          active_job.valid    = 1'b1;
          active_job.id       = ready_rows[best].id;
          active_job.burst    = ready_rows[best].burst;
          active_job.exec_cnt = '0;
          active_job.wait_cnt = ready_rows[best].wait_cnt;
          ready_rows[best]    = '0;
        end
      end
      if (active_job.valid && active_job.exec_cnt != '1)
        active_job.exec_cnt = active_job.exec_cnt + BURST_W'(1);
      // ageing: priority floored at zero, wait count saturating
      for (int i = 0; i < SLOTS; i++) begin
        if (ready_rows[i].valid) begin
          if (ready_rows[i].prio > PRIO_W'(aging_rate_q48))
            ready_rows[i].prio = ready_rows[i].prio - PRIO_W'(aging_rate_q48);
          else
            ready_rows[i].prio = '0;
          if (ready_rows[i].wait_cnt != '1)
            ready_rows[i].wait_cnt = ready_rows[i].wait_cnt + WAIT_W'(1);
        end
      end
      step_no = step_no + STEP_W'(1);
    end
    r.running_valid = active_job.valid;
    r.running_id    = active_job.valid ? active_job.id : '0;
    return r;
  endfunction

  function automatic int rows_in_use();
    int n = 0;
    foreach (ready_rows[i]) if (ready_rows[i].valid) n++;
    return n;
  endfunction

  // Half the draws span the full range; the other half are pinned near either end.
  function automatic bit [PRIO_W-1:0] rand_prio();
    case ($urandom_range(3))
      0:       return PRIO_W'($urandom_range(255));
      1:       return PRIO_W'($urandom_range(65535, 65280));
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  // Short bursts keep jobs retiring; the odd longer one lets the table back up.
  function automatic bit [BURST_W-1:0] rand_burst();
    if ($urandom_range(9) == 0) return BURST_W'($urandom_range(63, 8));
    return BURST_W'($urandom_range(7));
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Entered and left at a falling edge. valid is left high after a
  // transfer so back-to-back items never lower and raise it in one step; a gap
  // or settle() takes it down.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input bit [ID_W-1:0] id,
                           input bit [PRIO_W-1:0] prio, input bit [BURST_W-1:0] burst);
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid        <= 1'b1;
    req.opcode       <= op;
    req.job_id       <= id;
    req.job_priority <= prio;
    req.job_burst    <= burst;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    outcome_q.insert(outcome_q.size(), advance_schedule(op, id, prio, burst));
    @(negedge clk_i);
  endtask

  // Tick payload is don't-care, so it carries noise.
  task automatic send_tick();
    send_item(OP_TICK, ID_W'($urandom), PRIO_W'($urandom), BURST_W'($urandom));
  endtask

  // Stop offering, wait for every outstanding result, then let the block go quiet.
  task automatic settle();
    req.valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_aging_rate(input bit [RATE_W-1:0] rate);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    aging_rate_q48 = rate;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready toggled at the falling edge. A non-zero hold_left forces
  // a long stall, counted down here, so the output register and then the input
  // back up.
  // ---------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [STEP_W-1:0] want,
                                      input logic [STEP_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Every result transfer is matched against the oldest outstanding prediction.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatch_cnt++;
      end else begin
        want = outcome_q.pop_front();
        check_field("arrival_rejected", STEP_W'(want.arrival_rejected),
                    STEP_W'(rsp.arrival_rejected));
        check_field("running_valid", STEP_W'(want.running_valid),
                    STEP_W'(rsp.running_valid));
        check_field("running_id", STEP_W'(want.running_id), STEP_W'(rsp.running_id));
        check_field("finished_valid", STEP_W'(want.finished_valid),
                    STEP_W'(rsp.finished_valid));
        check_field("finished_id", STEP_W'(want.finished_id), STEP_W'(rsp.finished_id));
        check_field("finished_step", want.finished_step, rsp.finished_step);
        check_field("finished_wait", STEP_W'(want.finished_wait),
                    STEP_W'(rsp.finished_wait));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty tick, zero burst, extreme ids and priorities, both tie-breaks, an
  // arrival while a job runs, and priorities ageing down to the floor.
  task automatic test_dispatch_rules();
    set_aging_rate(RATE_RESET);
    send_tick();                                    // nothing to run yet
    send_item(OP_ARRIVE, 8'h00, 16'h0000, 16'h0000);  // zero burst, best priority
    send_item(OP_ARRIVE, 8'hFF, 16'hFFFF, 16'h0001);
    send_item(OP_ARRIVE, 8'h5A, 16'h0300, 16'h0003);
    send_item(OP_ARRIVE, 8'hA5, 16'h0300, 16'h0002);  // same priority, shorter burst
    send_item(OP_ARRIVE, 8'h3C, 16'h0300, 16'h0002);  // full tie, higher row loses
    send_tick();
    send_item(OP_ARRIVE, 8'h81, 16'h0180, 16'h0001);  // reports the job already running
    repeat (10) send_tick();
  endtask

  // Fill every row, then one more arrival must bounce.
  task automatic test_table_full();
    while (rows_in_use() < SLOTS)
      send_item(OP_ARRIVE, ID_W'($urandom), rand_prio(), rand_burst());
    send_item(OP_ARRIVE, 8'h77, 16'h1234, 16'h0004);
    send_tick();
  endtask

  // Random mix of arrivals and ticks; the arrival share varies per phase so the
  // table runs anywhere from nearly empty to saturated.
  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct,
                                     input bit [RATE_W-1:0] rate);
    int arrive_pct;
    set_aging_rate(rate);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    arrive_pct      = $urandom_range(45, 15);
    repeat (n) begin
      if ($urandom_range(99) < arrive_pct)
        send_item(OP_ARRIVE, ID_W'($urandom), rand_prio(), rand_burst());
      else
        send_tick();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    settle();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_left       = 300;
    repeat (10) begin
      if ($urandom_range(1) == 0)
        send_item(OP_ARRIVE, ID_W'($urandom), rand_prio(), rand_burst());
      else
        send_tick();
    end
  endtask

  initial begin
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    req.valid        = 1'b0;
    req.opcode       = OP_ARRIVE;
    req.job_id       = '0;
    req.job_priority = '0;
    req.job_burst    = '0;
    foreach (ready_rows[i]) ready_rows[i] = '0;
    active_job     = '0;
    step_no        = '0;
    aging_rate_q48 = RATE_RESET;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_dispatch_rules();
    test_table_full();
    test_random_traffic(460, 0, 0, RATE_RESET);
    test_random_traffic(460, 59, 0, 12'h000);
    test_random_traffic(460, 0, 59, 12'hFFF);
    test_random_traffic(460, 32, 32, RATE_W'($urandom_range(1023)));
    test_output_backpressure();

    settle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // About 1900 items in all; this timeout stops a hung run and reports
  // mismatches.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
